FILE: design/mcw_pkg.sv
// shared constants for the multi-client watchdog
package mcw_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam int INTERVAL_W = 24;
  localparam int MAXC_W     = 5;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_KICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIENTS = 1'd1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd1000;
  localparam logic [MAXC_W-1:0]     MAXC_RESET     = 5'd16;

endpackage

FILE: design/mcw_if.sv
// item channels of the multi-client watchdog
interface mcw_in_if #(
  parameter int ID_BITS = mcw_pkg::ID_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [mcw_pkg::OP_W-1:0]    operation;
  logic [ID_BITS-1:0]          client_id;

  modport source (output valid, output operation, output client_id, input ready);
  modport sink (input valid, input operation, input client_id, output ready);
endinterface

interface mcw_out_if #(
  parameter int ID_BITS = mcw_pkg::ID_BITS_DEF,
  parameter int CNT_W   = 5
);
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               expired;
  logic [ID_BITS-1:0] expired_id;
  logic [CNT_W-1:0]   active_count;
  logic               max_reached;

  modport source (output valid, output accepted, output expired, output expired_id,
                  output active_count, output max_reached, input ready);
  modport sink (input valid, input accepted, input expired, input expired_id,
                input active_count, input max_reached, output ready);
endinterface

FILE: design/mcw_table.sv
// client table: recency order, countdowns and single-pass update
module mcw_table #(
  parameter int TABLE_DEPTH = mcw_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = mcw_pkg::ID_BITS_DEF,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [mcw_pkg::OP_W-1:0]       operation,
  input  logic [ID_BITS-1:0]             client_id,
  input  logic [mcw_pkg::INTERVAL_W-1:0] interval_ticks,
  input  logic [mcw_pkg::MAXC_W-1:0]     max_clients,
  output logic                           accepted,
  output logic                           expired,
  output logic [ID_BITS-1:0]             expired_id,
  output logic [CNT_W-1:0]               active_count,
  output logic                           max_reached
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > mcw_pkg::MAXC_W) ? CNT_W : mcw_pkg::MAXC_W;
  localparam int RW    = mcw_pkg::INTERVAL_W;

  logic [ID_BITS-1:0] client [TABLE_DEPTH];
  logic [RW-1:0]      remaining [TABLE_DEPTH];
  logic [CNT_W-1:0]   count;
  logic               full_seen;

  logic [ID_BITS-1:0] client_next [TABLE_DEPTH];
  logic [RW-1:0]      remaining_next [TABLE_DEPTH];
  logic [CNT_W-1:0]   count_next;
  logic               full_seen_next;

  logic [ID_BITS-1:0] client_dn [TABLE_DEPTH];
  logic [RW-1:0]      remaining_dn [TABLE_DEPTH];
  logic [ID_BITS-1:0] client_up [TABLE_DEPTH];
  logic [RW-1:0]      remaining_up [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] lowest;
  logic [TABLE_DEPTH-1:0] ge_hit;
  logic [TABLE_DEPTH-1:0] gt_hit;
  logic                   found;
  logic [CMP_W-1:0]       limit;
  logic                   room;
  logic                   acc;
  logic [IDX_W-1:0]       old_idx;

  // neighbour taps for the shift towards and away from the front
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_nb
    if (g == 0) begin : g_first
      assign client_dn[g]    = client[g];
      assign remaining_dn[g] = remaining[g];
    end else begin : g_rest
      assign client_dn[g]    = client[g-1];
      assign remaining_dn[g] = remaining[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign client_up[g]    = client[g];
      assign remaining_up[g] = remaining[g];
    end else begin : g_inner
      assign client_up[g]    = client[g+1];
      assign remaining_up[g] = remaining[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count) && (client[i] == client_id);
    end
  end

  // first hit and the positions at or after it
  assign lowest = match & (~match + TABLE_DEPTH'(1));
  assign ge_hit = ~(lowest - TABLE_DEPTH'(1));
  assign gt_hit = ge_hit & ~lowest;
  assign found  = |match;

  assign limit = (CMP_W'(max_clients) < CMP_W'(TABLE_DEPTH)) ? CMP_W'(max_clients)
                                                              : CMP_W'(TABLE_DEPTH);
  assign room  = CMP_W'(count) < limit;

  always_comb begin
    count_next     = count;
    full_seen_next = full_seen;
    acc            = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      client_next[i]    = client[i];
      remaining_next[i] = remaining[i];
    end
    case (operation)
      mcw_pkg::OP_TICK: begin
        acc = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (remaining[i] != '0) begin
            remaining_next[i] = remaining[i] - RW'(1);
          end
        end
      end
      mcw_pkg::OP_KICK: begin
        acc = found || room;
        if (acc) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) begin
              client_next[i]    = client_id;
              remaining_next[i] = interval_ticks;
            end else if (!found || !gt_hit[i]) begin
              client_next[i]    = client_dn[i];
              remaining_next[i] = remaining_dn[i];
            end
          end
          if (!found) begin
            count_next = count + CNT_W'(1);
          end
          if (CMP_W'(count_next) >= limit) begin
            full_seen_next = 1'b1;
          end
        end
      end
      mcw_pkg::OP_REMOVE: begin
        acc = found;
        if (found) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (ge_hit[i]) begin
              client_next[i]    = client_up[i];
              remaining_next[i] = remaining_up[i];
            end
          end
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  // oldest client after this item
  assign old_idx      = IDX_W'(count_next - CNT_W'(1));
  assign accepted     = acc;
  assign expired      = (count_next != '0) && (remaining_next[old_idx] == '0);
  assign expired_id   = expired ? client_next[old_idx] : '0;
  assign active_count = count_next;
  assign max_reached  = full_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      full_seen <= 1'b0;
    end else if (fire) begin
      count     <= count_next;
      full_seen <= full_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        client[i]    <= client_next[i];
        remaining[i] <= remaining_next[i];
      end
    end
  end

endmodule

FILE: design/mcw_out_buf.sv
// result register with one skid entry
module mcw_out_buf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: design/multi_client_watchdog_core.sv
// top level of the multi-client watchdog
// Takes one item (tick, kick or remove) per clock while the buffer has room and returns one
// registered result per item. The whole table update, including the parallel id compare over
// all TABLE_DEPTH slots and the shift that keeps clients in kick order, is done in a single
// pass from the slot registers; a two-entry output buffer keeps the input ready while one
// result waits to be taken. Configuration writes are taken at any time but are meant for idle.
module multi_client_watchdog_core #(
  parameter int TABLE_DEPTH = mcw_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = mcw_pkg::ID_BITS_DEF,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  mcw_in_if.sink                         item_in,
  mcw_out_if.source                      result_out,
  input  logic                           cfg_we,
  input  logic [mcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RES_W = 1 + 1 + ID_BITS + CNT_W + 1;

  logic [mcw_pkg::INTERVAL_W-1:0] interval_ticks;
  logic [mcw_pkg::MAXC_W-1:0]     max_clients;

  logic               fire;
  logic               can_push;
  logic               accepted;
  logic               expired;
  logic [ID_BITS-1:0] expired_id;
  logic [CNT_W-1:0]   active_count;
  logic               max_reached;
  logic [RES_W-1:0]   res_in;
  logic [RES_W-1:0]   res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= mcw_pkg::INTERVAL_RESET;
      max_clients    <= mcw_pkg::MAXC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcw_pkg::REG_INTERVAL:    interval_ticks <= cfg_data[mcw_pkg::INTERVAL_W-1:0];
        mcw_pkg::REG_MAX_CLIENTS: max_clients    <= cfg_data[mcw_pkg::MAXC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item_in.ready = can_push;
  assign fire          = item_in.valid && can_push;

  mcw_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .CNT_W       (CNT_W)
  ) u_table (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .operation      (item_in.operation),
    .client_id      (item_in.client_id),
    .interval_ticks (interval_ticks),
    .max_clients    (max_clients),
    .accepted       (accepted),
    .expired        (expired),
    .expired_id     (expired_id),
    .active_count   (active_count),
    .max_reached    (max_reached)
  );

  assign res_in = {accepted, expired, expired_id, active_count, max_reached};

  mcw_out_buf #(
    .W (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res_in),
    .can_push  (can_push),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (res_out)
  );

  assign {result_out.accepted, result_out.expired, result_out.expired_id,
          result_out.active_count, result_out.max_reached} = res_out;

endmodule

FILE: dv/multi_client_watchdog_core_test.sv
// self-checking testbench for the multi-client watchdog core
`timescale 1ns / 1ps

module multi_client_watchdog_core_test;
  import mcw_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 175;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [INTERVAL_W-1:0] PH_INTERVAL [6] = '{24'd4, 24'd2, 24'd1, 24'hFFFFFF,
                                                        24'd0, 24'd6};
  localparam logic [CFG_DATA_W-1:0] PH_LIMIT [6] = '{24'd16, 24'd3, 24'd1, 24'd16,
                                                     24'd8, 24'd31};

  typedef struct packed {
    logic                accepted;
    logic                expired;
    logic [15:0]         expired_id;
    logic [MAXC_W-1:0]   active_count;
    logic                max_reached;
  } status_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [OP_W-1:0]      op;
    logic [CFG_DATA_W-1:0] arg;
    bit                   typed;
    status_t              want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mcw_in_if item_if ();
  mcw_out_if result_if ();

  multi_client_watchdog_core uut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog table as the block should hold it
  logic [15:0]           tbl_id   [DEPTH];
  logic [INTERVAL_W-1:0] tbl_left [DEPTH];
  int                    held = 0;
  bit                    full_flag = 1'b0;
  logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RESET;
  logic [MAXC_W-1:0]     cfg_max = MAXC_RESET;

  status_t expected_status [$];
  int      mismatches = 0;
  int      src_gap = 0;
  int      sink_gap = 0;
  logic    hold_req = 1'b0;
  int      cycle_count = 0;

  plan_row_t plan [26] = '{
    '{1'b0, REG_INTERVAL, OP_TICK,   24'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd0, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_REMOVE, 24'h1234, 1'b1, {1'b0, 1'b0, 16'h0000, 5'd0, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_UNUSED, 24'hFFFF, 1'b1, {1'b0, 1'b0, 16'h0000, 5'd0, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'hFFFF, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd1, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd2, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'hFFFF, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd2, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_REMOVE, 24'h0000, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd1, 1'b0}},
    '{1'b1, REG_INTERVAL, OP_TICK,   24'd0,    1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h00A5, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd2, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'hFFFF, 1'b1, {1'b1, 1'b1, 16'h00A5, 5'd2, 1'b0}},
    '{1'b1, REG_MAX_CLIENTS, OP_TICK, 24'd2,   1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h5A5A, 1'b1, {1'b0, 1'b1, 16'h00A5, 5'd2, 1'b0}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h00A5, 1'b1, {1'b1, 1'b1, 16'hFFFF, 5'd2, 1'b1}},
    '{1'b1, REG_MAX_CLIENTS, OP_TICK, 24'd0,   1'b0, '0},
    '{1'b1, REG_INTERVAL, OP_TICK,   24'hFFFFFF, 1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_REMOVE, 24'hFFFF, 1'b1, {1'b1, 1'b1, 16'h00A5, 5'd1, 1'b1}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h1111, 1'b1, {1'b0, 1'b1, 16'h00A5, 5'd1, 1'b1}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h00A5, 1'b1, {1'b1, 1'b0, 16'h0000, 5'd1, 1'b1}},
    '{1'b1, REG_MAX_CLIENTS, OP_TICK, 24'd31,  1'b0, '0},
    '{1'b1, REG_INTERVAL, OP_TICK,   24'd1,    1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h8001, 1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_TICK,   24'h0000, 1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_REMOVE, 24'h00A5, 1'b1, {1'b1, 1'b1, 16'h8001, 5'd1, 1'b1}},
    '{1'b0, REG_INTERVAL, OP_TICK,   24'h0000, 1'b1, {1'b1, 1'b1, 16'h8001, 5'd1, 1'b1}},
    '{1'b0, REG_INTERVAL, OP_KICK,   24'h7FFE, 1'b0, '0},
    '{1'b0, REG_INTERVAL, OP_REMOVE, 24'h7FFE, 1'b0, '0}
  };

  function automatic void drop_client(int pos);
    int i;
    for (i = pos; i + 1 < held; i++) begin
      tbl_id[i] = tbl_id[i + 1];
      tbl_left[i] = tbl_left[i + 1];
    end
    held--;
  endfunction

  function automatic void push_client(logic [15:0] id);
    int i;
    for (i = held; i > 0; i--) begin
      tbl_id[i] = tbl_id[i - 1];
      tbl_left[i] = tbl_left[i - 1];
    end
    tbl_id[0] = id;
    tbl_left[0] = cfg_interval;
    held++;
  endfunction

  function automatic status_t advance_watchdog(logic [OP_W-1:0] op, logic [15:0] id);
    status_t s;
    int hit;
    int cap;
    int i;
    s = '0;
    cap = (cfg_max < DEPTH) ? int'(cfg_max) : DEPTH;
    hit = -1;
    for (i = 0; i < held; i++) begin
      if (hit < 0 && tbl_id[i] == id) hit = i;
    end
    case (op)
      OP_TICK: begin
        for (i = 0; i < held; i++) begin
          if (tbl_left[i] != 0) tbl_left[i] = tbl_left[i] - 1'b1;
        end
        s.accepted = 1'b1;
      end
      OP_KICK: begin
        if (hit >= 0) begin
          drop_client(hit);
          push_client(id);
          s.accepted = 1'b1;
        end else if (held < cap) begin
          push_client(id);
          s.accepted = 1'b1;
        end
        if (s.accepted && held >= cap) full_flag = 1'b1;
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          drop_client(hit);
          s.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    if (held > 0 && tbl_left[held - 1] == 0) begin
      s.expired = 1'b1;
      s.expired_id = tbl_id[held - 1];
    end
    s.active_count = held[MAXC_W-1:0];
    s.max_reached = full_flag;
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [15:0] id, bit typed, status_t want);
    status_t s;
    while ($urandom_range(99) < src_gap) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.operation <= op;
    item_if.client_id <= id;
    do @(posedge clk); while (!item_if.ready);
    s = advance_watchdog(op, id);
    expected_status.push_back(typed ? want : s);
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_INTERVAL) cfg_interval = data[INTERVAL_W-1:0];
    else cfg_max = data[MAXC_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // receiver with random stalls and one long hold-off on request
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_if.ready <= ($urandom_range(99) >= sink_gap);
    end
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = {result_if.accepted, result_if.expired, result_if.expired_id,
             result_if.active_count, result_if.max_reached};
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected item", got, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", got.accepted, want.accepted);
        if (got.expired !== want.expired)
          report_mismatch("expired", got.expired, want.expired);
        if (got.expired_id !== want.expired_id)
          report_mismatch("expired_id", got.expired_id, want.expired_id);
        if (got.active_count !== want.active_count)
          report_mismatch("active_count", got.active_count, want.active_count);
        if (got.max_reached !== want.max_reached)
          report_mismatch("max_reached", got.max_reached, want.max_reached);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] pool [$];
    logic [OP_W-1:0] op;
    logic [15:0] id;
    int r;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.operation = OP_TICK;
    item_if.client_id = '0;
    cfg_we = 1'b0;
    cfg_index = REG_INTERVAL;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_gap = 22;
    sink_gap <= 49;
    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        drain_results();
        write_reg(plan[k].reg_idx, plan[k].arg);
      end else begin
        send_item(plan[k].op, plan[k].arg[15:0], plan[k].typed, plan[k].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_reg(REG_INTERVAL, PH_INTERVAL[p]);
      write_reg(REG_MAX_CLIENTS, PH_LIMIT[p]);
      case (p % 3)
        0: begin src_gap = 22; sink_gap <= 49; end
        1: begin src_gap = 49; sink_gap <= 22; end
        default: begin src_gap = 0; sink_gap <= 0; end
      endcase
      pool.delete();
      repeat ($urandom_range(20, 3)) pool.push_back(16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 35) op = OP_TICK;
        else if (r < 80) op = OP_KICK;
        else if (r < 95) op = OP_REMOVE;
        else op = OP_UNUSED;
        if ($urandom_range(99) < 85) id = pool[$urandom_range(pool.size() - 1)];
        else id = 16'($urandom);
        if (p == 0 && n == 40) hold_req <= 1'b1;
        send_item(op, id, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/mcw_pkg.sv
design/mcw_if.sv
design/mcw_table.sv
design/mcw_out_buf.sv
design/multi_client_watchdog_core.sv
dv/multi_client_watchdog_core_test.sv
